>>> design/plvs_pkg.sv
// ============================================================================
// plvs_pkg
// Shared constants, register codes and pipeline item types for the point
// light vertex shading pipeline.
// ============================================================================
package plvs_pkg;

    localparam int COORD_BITS     = 16;
    localparam int WEIGHT_BITS    = 8;
    localparam int DIFF_BITS      = 16;
    localparam int CH_BITS        = 8;
    localparam int NUM_CH         = 4;
    localparam int NUM_AXES       = 3;
    localparam int RANGE_BITS     = 32;
    localparam int COLOR_BITS     = NUM_CH * CH_BITS;
    localparam int SQ_BITS        = 2 * DIFF_BITS;
    localparam int SUM_BITS       = SQ_BITS + 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_LIGHT_X      = 3'd0,
        REG_LIGHT_Y      = 3'd1,
        REG_LIGHT_Z      = 3'd2,
        REG_RANGE_SQUARE = 3'd3,
        REG_LIGHT_COLOR  = 3'd4
    } cfg_reg_t;

    // element NUM_CH-1 is red, element 0 is alpha
    typedef logic [NUM_CH-1:0][CH_BITS-1:0] color_t;

    typedef struct packed {
        logic                  in_range;
        logic [RANGE_BITS-1:0] d2;
        color_t                acc;
    } dist_item_t;

    typedef struct packed {
        logic                   in_range;
        logic [WEIGHT_BITS:0]   weight;
        color_t                 acc;
    } weight_item_t;

endpackage

>>> design/plvs_dist.sv
// ============================================================================
// plvs_dist
// Three-stage squared distance: axis magnitudes, squares, sum and range test.
// ============================================================================
module plvs_dist (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      adv,
    input  logic                                      in_valid,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    px,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    py,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    pz,
    input  plvs_pkg::color_t                          acc,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    light_x,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    light_y,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    light_z,
    input  logic [plvs_pkg::RANGE_BITS-1:0]           range_square,
    output logic                                      out_valid,
    output plvs_pkg::dist_item_t                      out_item
);

    logic signed [plvs_pkg::COORD_BITS-1:0] p_coord [plvs_pkg::NUM_AXES];
    logic signed [plvs_pkg::COORD_BITS-1:0] l_coord [plvs_pkg::NUM_AXES];
    logic signed [plvs_pkg::COORD_BITS:0]   diff [plvs_pkg::NUM_AXES];
    logic [plvs_pkg::COORD_BITS:0]          mag [plvs_pkg::NUM_AXES];
    logic [plvs_pkg::NUM_AXES-1:0]          far_axis;

    logic [plvs_pkg::DIFF_BITS-1:0]         mag_reg [plvs_pkg::NUM_AXES];
    logic                                   far1_reg;
    plvs_pkg::color_t                       acc1_reg;
    logic                                   v1_reg;

    logic [plvs_pkg::SQ_BITS-1:0]           sq_reg [plvs_pkg::NUM_AXES];
    logic                                   far2_reg;
    plvs_pkg::color_t                       acc2_reg;
    logic                                   v2_reg;

    logic [plvs_pkg::SUM_BITS-1:0]          d2_sum;
    plvs_pkg::dist_item_t                   item_next;
    plvs_pkg::dist_item_t                   item_reg;
    logic                                   v3_reg;

    assign p_coord[0] = px;
    assign p_coord[1] = py;
    assign p_coord[2] = pz;
    assign l_coord[0] = light_x;
    assign l_coord[1] = light_y;
    assign l_coord[2] = light_z;

    always_comb
    begin
        for (int i = 0; i < plvs_pkg::NUM_AXES; i++)
        begin
            diff[i] = {p_coord[i][plvs_pkg::COORD_BITS-1], p_coord[i]}
                    - {l_coord[i][plvs_pkg::COORD_BITS-1], l_coord[i]};
            mag[i]  = diff[i][plvs_pkg::COORD_BITS] ? unsigned'(-diff[i])
                                                    : unsigned'(diff[i]);
            far_axis[i] = (mag[i] >> plvs_pkg::DIFF_BITS) != '0;
        end
    end

    assign d2_sum = plvs_pkg::SUM_BITS'(sq_reg[0]) + plvs_pkg::SUM_BITS'(sq_reg[1])
                  + plvs_pkg::SUM_BITS'(sq_reg[2]);

    always_comb
    begin
        item_next.in_range = !far2_reg && (d2_sum < plvs_pkg::SUM_BITS'(range_square));
        item_next.d2       = d2_sum[plvs_pkg::RANGE_BITS-1:0];
        item_next.acc      = acc2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < plvs_pkg::NUM_AXES; i++)
            begin
                mag_reg[i] <= plvs_pkg::DIFF_BITS'(mag[i]);
                sq_reg[i]  <= plvs_pkg::SQ_BITS'(mag_reg[i] * mag_reg[i]);
            end
            far1_reg <= |far_axis;
            acc1_reg <= acc;
            far2_reg <= far1_reg;
            acc2_reg <= acc1_reg;
            item_reg <= item_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item_reg;

endmodule

>>> design/plvs_div.sv
// ============================================================================
// plvs_div
// Restoring divider, one quotient bit per stage, giving the falloff weight
// 2^WEIGHT_BITS - floor(2^WEIGHT_BITS * d2 / range_square).
// ============================================================================
module plvs_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  plvs_pkg::dist_item_t              in_item,
    input  logic [plvs_pkg::RANGE_BITS-1:0]   range_square,
    output logic                              out_valid,
    output plvs_pkg::weight_item_t            out_item
);

    localparam int W  = plvs_pkg::WEIGHT_BITS;
    localparam int RB = plvs_pkg::RANGE_BITS;

    logic [RB-1:0]        rem_src [W];
    logic [W-1:0]         q_src [W];
    logic                 inside_src [W];
    plvs_pkg::color_t     acc_src [W];
    logic                 v_src [W];

    logic [RB-1:0]        rem_reg [W];
    logic [W-1:0]         q_reg [W];
    logic                 inside_reg [W];
    plvs_pkg::color_t     acc_reg [W];
    logic [W-1:0]         v_reg;

    for (genvar k = 0; k < W; k++)
    begin : g_stage
        logic [RB:0]   rem2;
        logic          ge;
        logic [RB-1:0] rem_next;
        logic [W-1:0]  q_next;

        if (k == 0)
        begin : g_first
            assign rem_src[k]    = in_item.d2;
            assign q_src[k]      = '0;
            assign inside_src[k] = in_item.in_range;
            assign acc_src[k]    = in_item.acc;
            assign v_src[k]      = in_valid;
        end
        else
        begin : g_rest
            assign rem_src[k]    = rem_reg[k-1];
            assign q_src[k]      = q_reg[k-1];
            assign inside_src[k] = inside_reg[k-1];
            assign acc_src[k]    = acc_reg[k-1];
            assign v_src[k]      = v_reg[k-1];
        end

        assign rem2     = {rem_src[k], 1'b0};
        assign ge       = rem2 >= {1'b0, range_square};
        assign rem_next = ge ? RB'(rem2 - {1'b0, range_square}) : RB'(rem2);
        assign q_next   = {q_src[k][W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_src[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]    <= rem_next;
                q_reg[k]      <= q_next;
                inside_reg[k] <= inside_src[k];
                acc_reg[k]    <= acc_src[k];
            end
        end
    end

    assign out_valid         = v_reg[W-1];
    assign out_item.in_range = inside_reg[W-1];
    assign out_item.weight   = {1'b1, {W{1'b0}}} - {1'b0, q_reg[W-1]};
    assign out_item.acc      = acc_reg[W-1];

endmodule

>>> design/plvs_shade.sv
// ============================================================================
// plvs_shade
// Scale the light colour by the weight, add to the gathered colour for in-range
// items and saturate; the second stage is the output register.
// ============================================================================
module plvs_shade (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              in_valid,
    input  plvs_pkg::weight_item_t            in_item,
    input  plvs_pkg::color_t                  light_color,
    output logic                              out_valid,
    output plvs_pkg::color_t                  out_color,
    output logic                              out_lit
);

    localparam int CB = plvs_pkg::CH_BITS;
    localparam int W  = plvs_pkg::WEIGHT_BITS;
    localparam int PB = CB + W + 1;

    logic [PB-1:0]        prod [plvs_pkg::NUM_CH];
    logic [CB:0]          add_reg [plvs_pkg::NUM_CH];
    logic                 inside_reg;
    plvs_pkg::color_t     acc_reg;
    logic                 v1_reg;

    logic [CB+1:0]        sum [plvs_pkg::NUM_CH];
    plvs_pkg::color_t     color_next;
    plvs_pkg::color_t     color_reg;
    logic                 lit_reg;
    logic                 v2_reg;

    always_comb
    begin
        for (int i = 0; i < plvs_pkg::NUM_CH; i++)
        begin
            prod[i] = PB'(light_color[i]) * PB'(in_item.weight);
            sum[i]  = (CB+2)'(acc_reg[i]) + (CB+2)'(add_reg[i]);
            if (!inside_reg)
            begin
                color_next[i] = acc_reg[i];
            end
            else if (sum[i] > (CB+2)'({CB{1'b1}}))
            begin
                color_next[i] = {CB{1'b1}};
            end
            else
            begin
                color_next[i] = sum[i][CB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < plvs_pkg::NUM_CH; i++)
            begin
                add_reg[i] <= prod[i][PB-1:W];
            end
            inside_reg <= in_item.in_range;
            acc_reg    <= in_item.acc;
            color_reg  <= color_next;
            lit_reg    <= inside_reg;
        end
    end

    assign out_valid = v2_reg;
    assign out_color = color_reg;
    assign out_lit   = lit_reg;

endmodule

>>> design/point_light_vertex_shade_top.sv
// ============================================================================
// point_light_vertex_shade_top
// Point light with quadratic falloff: adds the weighted light colour to a
// gathered RGBA colour when the point lies inside the light's range.
//
// Channel   Signals                              Direction
// input     in_valid/in_ready, px py pz acc_*    into block
// output    out_valid/out_ready, out_* lit       out of block
// config    cfg_we, cfg_index, cfg_data          into block, write only
//
// One transaction per cycle sustained while the output is not stalled; items
// pass distance, the weight divider's eight quotient-bit stages and shading.
// Reset clears valid bits and all configuration registers to zero.
// A stall at the output freezes every stage together; in_ready follows.
// ============================================================================
module point_light_vertex_shade_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    output logic                                      in_ready,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    px,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    py,
    input  logic signed [plvs_pkg::COORD_BITS-1:0]    pz,
    input  logic [plvs_pkg::CH_BITS-1:0]              acc_r,
    input  logic [plvs_pkg::CH_BITS-1:0]              acc_g,
    input  logic [plvs_pkg::CH_BITS-1:0]              acc_b,
    input  logic [plvs_pkg::CH_BITS-1:0]              acc_a,
    output logic                                      out_valid,
    input  logic                                      out_ready,
    output logic [plvs_pkg::CH_BITS-1:0]              out_r,
    output logic [plvs_pkg::CH_BITS-1:0]              out_g,
    output logic [plvs_pkg::CH_BITS-1:0]              out_b,
    output logic [plvs_pkg::CH_BITS-1:0]              out_a,
    output logic                                      lit,
    input  logic                                      cfg_we,
    input  logic [plvs_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [plvs_pkg::CFG_DATA_BITS-1:0]        cfg_data
);

    logic signed [plvs_pkg::COORD_BITS-1:0] light_x_reg;
    logic signed [plvs_pkg::COORD_BITS-1:0] light_y_reg;
    logic signed [plvs_pkg::COORD_BITS-1:0] light_z_reg;
    logic [plvs_pkg::RANGE_BITS-1:0]        range_square_reg;
    logic [plvs_pkg::COLOR_BITS-1:0]        light_color_reg;

    logic                                   adv;
    plvs_pkg::color_t                       acc_in;
    logic                                   dist_valid;
    plvs_pkg::dist_item_t                   dist_item;
    logic                                   div_valid;
    plvs_pkg::weight_item_t                 div_item;
    plvs_pkg::color_t                       out_color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg      <= '0;
            light_y_reg      <= '0;
            light_z_reg      <= '0;
            range_square_reg <= '0;
            light_color_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (plvs_pkg::cfg_reg_t'(cfg_index))
                plvs_pkg::REG_LIGHT_X:
                    light_x_reg <= cfg_data[plvs_pkg::COORD_BITS-1:0];
                plvs_pkg::REG_LIGHT_Y:
                    light_y_reg <= cfg_data[plvs_pkg::COORD_BITS-1:0];
                plvs_pkg::REG_LIGHT_Z:
                    light_z_reg <= cfg_data[plvs_pkg::COORD_BITS-1:0];
                plvs_pkg::REG_RANGE_SQUARE:
                    range_square_reg <= cfg_data[plvs_pkg::RANGE_BITS-1:0];
                plvs_pkg::REG_LIGHT_COLOR:
                    light_color_reg <= cfg_data[plvs_pkg::COLOR_BITS-1:0];
                default:
                    ;
            endcase
        end
    end

    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign acc_in   = {acc_r, acc_g, acc_b, acc_a};

    plvs_dist u_dist (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (in_valid),
        .px           (px),
        .py           (py),
        .pz           (pz),
        .acc          (acc_in),
        .light_x      (light_x_reg),
        .light_y      (light_y_reg),
        .light_z      (light_z_reg),
        .range_square (range_square_reg),
        .out_valid    (dist_valid),
        .out_item     (dist_item)
    );

    plvs_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .adv          (adv),
        .in_valid     (dist_valid),
        .in_item      (dist_item),
        .range_square (range_square_reg),
        .out_valid    (div_valid),
        .out_item     (div_item)
    );

    plvs_shade u_shade (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (div_valid),
        .in_item     (div_item),
        .light_color (plvs_pkg::color_t'(light_color_reg)),
        .out_valid   (out_valid),
        .out_color   (out_color),
        .out_lit     (lit)
    );

    assign out_r = out_color[3];
    assign out_g = out_color[2];
    assign out_b = out_color[1];
    assign out_a = out_color[0];

    // hold every stage while the output is stalled
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable({dist_valid, div_valid, out_valid}))
        else $error("pipeline valid bits moved during a stall");

    a_out_rises_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(adv))
        else $error("output became valid without an advance");

    a_accept_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && out_valid |-> out_ready)
        else $error("transaction accepted while output held");

endmodule

>>> tb/sv/point_light_vertex_shade_top_tb.sv
// ============================================================================
// point_light_vertex_shade_top_tb
// Self-checking bench for the point light shading pipeline. A directed table
// covers register extremes, the range boundary, zero range, far points and
// channel saturation. Random phases follow, each with its own light setup,
// and most points fall near the light. Accepted points queue colors from the
// table or a local predictor; each output transaction is checked in order
// against the oldest queued color. Both handshakes idle in random bursts.
// One long output stall backs up the pipeline, and one input pause drains it.
// ============================================================================
module point_light_vertex_shade_top_tb;

    import plvs_pkg::*;

    localparam int PIPE_LATENCY   = 13;
    localparam int LONG_HOLD      = 64;
    localparam int RAND_PHASES    = 7;
    localparam int PHASE_ITEMS    = 250;
    localparam int MAX_REPORTS    = 50;
    localparam int WATCHDOG_LIMIT = 800000;
    localparam int CH_MAX         = (1 << CH_BITS) - 1;
    localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
    localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        color_t                       acc;
    } vertex_t;

    typedef struct {
        color_t rgba;
        logic   lit;
    } shade_t;

    typedef struct {
        logic signed [COORD_BITS-1:0] x;
        logic signed [COORD_BITS-1:0] y;
        logic signed [COORD_BITS-1:0] z;
        logic [RANGE_BITS-1:0]        range_sq;
        color_t                       color;
    } light_t;

    typedef struct {
        int unsigned setup;
        vertex_t     v;
        bit          typed;
        shade_t      want;
    } dir_row_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic signed [COORD_BITS-1:0] px        = '0;
    logic signed [COORD_BITS-1:0] py        = '0;
    logic signed [COORD_BITS-1:0] pz        = '0;
    logic [CH_BITS-1:0]           acc_r     = '0;
    logic [CH_BITS-1:0]           acc_g     = '0;
    logic [CH_BITS-1:0]           acc_b     = '0;
    logic [CH_BITS-1:0]           acc_a     = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic [CH_BITS-1:0]           out_r;
    logic [CH_BITS-1:0]           out_g;
    logic [CH_BITS-1:0]           out_b;
    logic [CH_BITS-1:0]           out_a;
    logic                         lit;
    logic                         cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0]    cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]     cfg_data  = '0;

    light_t      light_cfg = '{16'sh0000, 16'sh0000, 16'sh0000, 32'h0, 32'h0};
    shade_t      shaded_q [$];
    int unsigned mismatch_count    = 0;
    bit          idle_on           = 1'b1;
    bit          long_hold_pending = 1'b0;
    string       ch_port [NUM_CH]  = '{"out_a", "out_b", "out_g", "out_r"};

    light_t dir_setups [5] = '{
        '{16'sh0000, 16'sh0000, 16'sh0000, 32'h0000_0000, 32'h0000_0000},
        '{16'sh0000, 16'sh0000, 16'sh0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
        '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'd1,         32'h8040_2010},
        '{16'sh8000, 16'sh7FFF, 16'sh8000, 32'd100,       32'hC864_3200},
        '{16'shFFFF, 16'sh0001, 16'sh0010, 32'd256,       32'h0000_0000}
    };

    dir_row_t dir_rows [21] = '{
        '{0, '{16'sh0000, 16'sh0000, 16'sh0000, 32'h0000_0000}, 1, '{32'h0000_0000, 1'b0}},
        '{0, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 1'b0}},
        '{0, '{16'sh8000, 16'sh8000, 16'sh8000, 32'h5AA5_0FF0}, 1, '{32'h5AA5_0FF0, 1'b0}},
        '{0, '{16'sh0000, 16'shFFFF, 16'sh0001, 32'h0180_7FFE}, 1, '{32'h0180_7FFE, 1'b0}},
        '{1, '{16'sh0000, 16'sh0000, 16'sh0000, 32'h0000_0000}, 1, '{32'hFFFF_FFFF, 1'b1}},
        '{1, '{16'sh0000, 16'sh0000, 16'sh0000, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 1'b1}},
        '{1, '{16'sh8000, 16'sh8000, 16'sh8000, 32'h0000_0000}, 0, '{32'h0000_0000, 1'b0}},
        '{1, '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h1020_3040}, 0, '{32'h0000_0000, 1'b0}},
        '{1, '{16'sh8000, 16'sh0000, 16'sh0000, 32'h8080_8080}, 0, '{32'h0000_0000, 1'b0}},
        '{2, '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'h0000_0000}, 1, '{32'h8040_2010, 1'b1}},
        '{2, '{16'sh7FFE, 16'sh8000, 16'sh7FFF, 32'h0102_0304}, 1, '{32'h0102_0304, 1'b0}},
        '{2, '{16'sh8000, 16'sh7FFF, 16'sh8000, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 1'b0}},
        '{2, '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'hFFFF_FFFF}, 1, '{32'hFFFF_FFFF, 1'b1}},
        '{3, '{16'sh800A, 16'sh7FFF, 16'sh8000, 32'h0000_0000}, 1, '{32'h0000_0000, 1'b0}},
        '{3, '{16'sh8009, 16'sh7FFB, 16'sh8001, 32'h1122_3344}, 0, '{32'h0000_0000, 1'b0}},
        '{3, '{16'sh8000, 16'sh7FFF, 16'sh8000, 32'h3737_3737}, 1, '{32'hFF9B_6937, 1'b1}},
        '{3, '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 32'hAAAA_5555}, 1, '{32'hAAAA_5555, 1'b0}},
        '{4, '{16'shFFFF, 16'sh0001, 16'sh0010, 32'h1234_5678}, 1, '{32'h1234_5678, 1'b1}},
        '{4, '{16'sh000F, 16'sh0001, 16'sh0010, 32'hFEDC_BA98}, 1, '{32'hFEDC_BA98, 1'b0}},
        '{4, '{16'sh000E, 16'sh0001, 16'sh0010, 32'h0F1E_2D3C}, 0, '{32'h0000_0000, 1'b0}},
        '{4, '{16'shFFFF, 16'sh0001, 16'sh0001, 32'hC3C3_3C3C}, 0, '{32'h0000_0000, 1'b0}}
    };

    point_light_vertex_shade_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .px        (px),
        .py        (py),
        .pz        (pz),
        .acc_r     (acc_r),
        .acc_g     (acc_g),
        .acc_b     (acc_b),
        .acc_a     (acc_a),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_r     (out_r),
        .out_g     (out_g),
        .out_b     (out_b),
        .out_a     (out_a),
        .lit       (lit),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic shade_t shade_point(input vertex_t v);
        longint delta [NUM_AXES];
        longint d2;
        longint weight;
        longint sum;
        bit     near;
        shade_t res;
        delta[0] = longint'(v.x) - longint'(light_cfg.x);
        delta[1] = longint'(v.y) - longint'(light_cfg.y);
        delta[2] = longint'(v.z) - longint'(light_cfg.z);
        near = 1'b1;
        d2 = 0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (delta[k] < 0)
                delta[k] = -delta[k];
            if (delta[k] >= (longint'(1) << DIFF_BITS))
                near = 1'b0;
        end
        if (near)
        begin
            d2 = delta[0] * delta[0] + delta[1] * delta[1] + delta[2] * delta[2];
            near = d2 < longint'(light_cfg.range_sq);
        end
        res.rgba = v.acc;
        res.lit  = near;
        if (near)
        begin
            weight = (longint'(1) << WEIGHT_BITS)
                     - (d2 << WEIGHT_BITS) / longint'(light_cfg.range_sq);
            for (int k = 0; k < NUM_CH; k++)
            begin
                sum = longint'(v.acc[k])
                      + ((longint'(light_cfg.color[k]) * weight) >> WEIGHT_BITS);
                res.rgba[k] = (sum > CH_MAX) ? CH_MAX[CH_BITS-1:0] : sum[CH_BITS-1:0];
            end
        end
        return res;
    endfunction

    function automatic logic signed [COORD_BITS-1:0] near_coord(
        input logic signed [COORD_BITS-1:0] base,
        input int                           reach
    );
        int c;
        c = int'(base) + int'($urandom_range(0, 2 * reach)) - reach;
        if (c > COORD_MAX)
            c = COORD_MAX;
        if (c < COORD_MIN)
            c = COORD_MIN;
        return c[COORD_BITS-1:0];
    endfunction

    function automatic light_t random_light(input int phase, output int reach);
        light_t s;
        longint rsq;
        s.x     = COORD_BITS'($urandom);
        s.y     = COORD_BITS'($urandom);
        s.z     = COORD_BITS'($urandom);
        s.color = $urandom;
        case (phase % 3)
            0:       reach = $urandom_range(1, 64);
            1:       reach = $urandom_range(65, 4096);
            default: reach = $urandom_range(4097, 37000);
        endcase
        rsq = longint'(reach) * reach + $urandom_range(0, 2 * reach);
        s.range_sq = rsq[RANGE_BITS-1:0];
        if (phase == 2)
        begin
            reach      = 37837;
            s.range_sq = '1;
        end
        return s;
    endfunction

    function automatic vertex_t random_vertex(input light_t s, input int reach);
        vertex_t v;
        v.acc = $urandom;
        if ($urandom_range(0, 7) == 0)
        begin
            v.x = COORD_BITS'($urandom);
            v.y = COORD_BITS'($urandom);
            v.z = COORD_BITS'($urandom);
        end
        else
        begin
            v.x = near_coord(s.x, reach);
            v.y = near_coord(s.y, reach);
            v.z = near_coord(s.z, reach);
        end
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (shaded_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(
        input logic [CFG_INDEX_BITS-1:0] index,
        input logic [CFG_DATA_BITS-1:0]  data
    );
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        case (index)
            REG_LIGHT_X:      light_cfg.x        = data[COORD_BITS-1:0];
            REG_LIGHT_Y:      light_cfg.y        = data[COORD_BITS-1:0];
            REG_LIGHT_Z:      light_cfg.z        = data[COORD_BITS-1:0];
            REG_RANGE_SQUARE: light_cfg.range_sq = data[RANGE_BITS-1:0];
            REG_LIGHT_COLOR:  light_cfg.color    = data[COLOR_BITS-1:0];
            default:          ;
        endcase
    endtask

    task automatic program_light(input light_t s);
        drain_pipeline();
        write_reg(REG_LIGHT_X, {16'($urandom), s.x});
        write_reg(REG_LIGHT_Y, {16'($urandom), s.y});
        write_reg(REG_LIGHT_Z, {16'($urandom), s.z});
        write_reg(REG_RANGE_SQUARE, s.range_sq);
        write_reg(REG_LIGHT_COLOR, s.color);
        for (int i = int'(REG_LIGHT_COLOR) + 1; i < (1 << CFG_INDEX_BITS); i++)
            write_reg(i[CFG_INDEX_BITS-1:0], $urandom);
        cfg_we <= 1'b0;
    endtask

    task automatic offer_vertex(input vertex_t v, input bit typed, input shade_t want);
        in_valid <= 1'b1;
        px       <= v.x;
        py       <= v.y;
        pz       <= v.z;
        acc_r    <= v.acc[NUM_CH-1];
        acc_g    <= v.acc[2];
        acc_b    <= v.acc[1];
        acc_a    <= v.acc[0];
        do
            @(posedge clk);
        while (!in_ready);
        if (typed)
            shaded_q.push_back(want);
        else
            shaded_q.push_back(shade_point(v));
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    initial
    begin
        forever
        begin
            if (long_hold_pending)
            begin
                long_hold_pending = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        shade_t got;
        shade_t want;
        string  bad;
        if (rst_n && out_valid && out_ready)
        begin
            got.rgba = {out_r, out_g, out_b, out_a};
            got.lit  = lit;
            if (shaded_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected transaction rgba=%h lit=%b",
                                          got.rgba, got.lit));
            end
            else
            begin
                want = shaded_q.pop_front();
                bad  = "";
                for (int k = NUM_CH - 1; k >= 0; k--)
                begin
                    if (got.rgba[k] !== want.rgba[k])
                        bad = {bad, " ", ch_port[k]};
                end
                if (got.lit !== want.lit)
                    bad = {bad, " lit"};
                if (bad != "")
                    report_mismatch($sformatf("bad%s: got rgba=%h lit=%b, want rgba=%h lit=%b",
                                              bad, got.rgba, got.lit, want.rgba, want.lit));
            end
        end
    end

    initial
    begin
        #(WATCHDOG_LIMIT);
        $display("point_light_vertex_shade_top_tb failed");
        $finish;
    end

    initial
    begin
        light_t      setup;
        shade_t      no_shade;
        int          reach;
        int unsigned cur_setup;
        no_shade.rgba = '0;
        no_shade.lit  = 1'b0;
        cur_setup     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].setup != cur_setup)
            begin
                cur_setup = dir_rows[i].setup;
                program_light(dir_setups[cur_setup]);
            end
            offer_vertex(dir_rows[i].v, dir_rows[i].typed, dir_rows[i].want);
        end

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            setup = random_light(p, reach);
            program_light(setup);
            idle_on = (p != 1) && (p != RAND_PHASES - 1);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == 40)
                    long_hold_pending = 1'b1;
                if (p == 3 && n == 120)
                begin
                    in_valid <= 1'b0;
                    while (shaded_q.size() != 0)
                        @(posedge clk);
                end
                offer_vertex(random_vertex(setup, reach), 1'b0, no_shade);
            end
        end

        in_valid <= 1'b0;
        while (shaded_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0)
            $display("point_light_vertex_shade_top_tb passed");
        else
            $display("point_light_vertex_shade_top_tb failed");
        $finish;
    end

endmodule

>>> point_light_vertex_shade_top.f
design/plvs_pkg.sv
design/plvs_dist.sv
design/plvs_div.sv
design/plvs_shade.sv
design/point_light_vertex_shade_top.sv
tb/sv/point_light_vertex_shade_top_tb.sv
